[hdl/dkss_pkg.sv]
// ----------------------------------------------------------------------------
// dkss_pkg
// Shared constants for the day-keyed sorted sample store.
// ----------------------------------------------------------------------------
package dkss_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W = 16 + CNT_W;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_AVG   = 2'd2;
  localparam logic [1:0] KIND_LAST  = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_FOUND    = 3'd4;
  localparam logic [2:0] ST_MISSING  = 3'd5;

endpackage

[hdl/dkss_ram.sv]
// ----------------------------------------------------------------------------
// dkss_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module dkss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/dkss_div.sv]
// ----------------------------------------------------------------------------
// dkss_div
// Restoring divider, one quotient bit per cycle: sum / count.
// ----------------------------------------------------------------------------
module dkss_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dkss_pkg::SUM_W-1:0] dividend,
  input  logic [dkss_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [15:0]               quotient
);
  import dkss_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [CNT_W:0]    trial;

  assign trial = {rem[CNT_W-1:0], quo[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W);
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo[15:0];

  assert property (@(posedge clk) disable iff (rst) start |=> busy);
  assert property (@(posedge clk) disable iff (rst) done |-> !busy);

endmodule

[hdl/day_keyed_sorted_sample_store.sv]
// ----------------------------------------------------------------------------
// day_keyed_sorted_sample_store
// Sorted (day, value) table with store, get, average and newest-entry words.
//
//  channel | signals                                         | dir
//  in      | in_valid in_stall kind today sample age_*       | in
//  out     | out_valid out_stall status result_value result_age | out
//
// One word at a time; in_stall is high from acceptance until the result
// word is taken. Get and average walk the table through one RAM port; last
// reads only the newest entry. A store walks down to its slot, then moves
// entries one at a time (up to insert, down to evict); average adds a divide.
// The longest word is a store of the oldest day into a table one short of
// full. Reset empties the table at once via the count.
// ----------------------------------------------------------------------------
module day_keyed_sorted_sample_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [15:0]        today,
  input  logic [15:0]        sample,
  input  logic [15:0]        age_days,
  input  logic signed [16:0] age_from,
  input  logic signed [16:0] age_to,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [15:0]        result_value,
  output logic signed [16:0] result_age
);
  import dkss_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_EVICT = 9'b000001000,
    S_SHRD  = 9'b000010000,
    S_SHWR  = 9'b000100000,
    S_INS   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t           state;
  logic [1:0]       op;
  logic [15:0]      day_q, val_q, want;
  logic signed [16:0] from_q, to_q;
  logic [CNT_W-1:0] count, idx;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] hits;
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [31:0]      ram_wdata, ram_rdata;
  logic [15:0]      rd_day, rd_val;
  logic signed [16:0] ago;
  logic             div_start, div_done;
  logic [15:0]      div_q;
  logic [IDX_W-1:0] walk;

  assign rd_day = ram_rdata[31:16];
  assign rd_val = ram_rdata[15:0];
  assign ago    = $signed({1'b0, day_q}) - $signed({1'b0, rd_day});

  dkss_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  dkss_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum), .divisor(hits),
    .done(div_done), .quotient(div_q)
  );

  // walk index: descending for store/get, ascending for average
  assign walk = IDX_W'(idx - 1'b1);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = walk;
    ram_wdata = {day_q, val_q};
    unique case (state)
      S_IDLE, S_DIV, S_OUT: ram_addr = walk;
      S_RD, S_CHK: begin
        if (op == KIND_AVG) ram_addr = IDX_W'(idx);
      end
      S_EVICT: ram_addr = IDX_W'(idx);
      S_SHRD:  ram_addr = (status == ST_EVICTED) ? IDX_W'(idx + 1'b1) : walk;
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(idx);
        ram_wdata = ram_rdata;
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(idx);
        if (status == ST_REPLACED) ram_wdata = {day_q, val_q};
      end
      default: ram_addr = walk;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          op     <= kind;
          day_q  <= today;
          val_q  <= sample;
          want   <= today - age_days;
          from_q <= age_from;
          to_q   <= age_to;
          sum    <= '0;
          hits   <= '0;
          status <= ST_MISSING;
          result_value <= '0;
          result_age   <= '0;
          if (kind == KIND_AVG) begin
            idx   <= '0;
            state <= (count == 0) ? S_OUT : S_RD;
          end else if (kind == KIND_LAST) begin
            idx   <= count;
            state <= (count == 0) ? S_OUT : S_RD;
          end else begin
            idx   <= count;
            if (count == 0) begin
              if (kind == KIND_STORE) begin
                status <= ST_INSERTED;
                state  <= S_INS;
              end else begin
                state <= S_OUT;
              end
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          state <= S_RD;
          unique case (op)
            KIND_LAST: begin
              status       <= ST_FOUND;
              result_value <= rd_val;
              result_age   <= ago;
              state        <= S_OUT;
            end
            KIND_GET: begin
              if (rd_day == want) begin
                status       <= ST_FOUND;
                result_value <= rd_val;
                state        <= S_OUT;
              end else if (rd_day < want || idx == 1) begin
                state <= S_OUT;
              end else begin
                idx <= idx - 1'b1;
              end
            end
            KIND_AVG: begin
              if (ago >= from_q && ago <= to_q) begin
                sum  <= sum + SUM_W'(rd_val);
                hits <= hits + 1'b1;
              end
              if (idx == count - 1'b1) begin
                state <= S_DIV;
                div_start <= 1'b1;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: begin
              // store: idx counts entries at or below candidate slot
              if (rd_day == day_q) begin
                status <= ST_REPLACED;
                idx    <= idx - 1'b1;
                state  <= S_INS;
              end else if (rd_day < day_q) begin
                // insert at idx, or at idx-1 when a full table evicts
                if (count == CNT_W'(TABLE_DEPTH)) begin
                  status <= ST_EVICTED;
                  hits   <= idx;
                  idx    <= '0;
                  state  <= S_EVICT;
                end else begin
                  status <= ST_INSERTED;
                  hits   <= idx;
                  idx    <= count;
                  state  <= (count == idx) ? S_INS : S_SHRD;
                end
              end else if (idx == 1) begin
                if (count == CNT_W'(TABLE_DEPTH)) begin
                  status <= ST_DROPPED;
                  state  <= S_OUT;
                end else begin
                  status <= ST_INSERTED;
                  hits   <= '0;
                  idx    <= count;
                  state  <= S_SHRD;
                end
              end else begin
                idx <= idx - 1'b1;
              end
            end
          endcase
        end
        // eviction: shift entries 1..hits-1 down by one, then insert at hits-1
        S_EVICT: state <= (idx == hits - 1'b1) ? S_INS : S_SHRD;
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          if (status == ST_EVICTED) begin
            idx   <= idx + 1'b1;
            state <= (idx + 1'b1 == hits - 1'b1) ? S_INS : S_SHRD;
          end else if (idx - 1'b1 == hits) begin
            idx   <= hits;
            state <= S_INS;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_SHRD;
          end
        end
        S_INS: begin
          if (status == ST_INSERTED) count <= count + 1'b1;
          state <= S_OUT;
        end
        S_DIV: if (div_done) begin
          if (hits != 0) begin
            status       <= ST_FOUND;
            result_value <= div_q;
          end
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(TABLE_DEPTH))
    else $error("table count overflow");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("result shown while idle");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_MISSING) |-> (result_value == 0 && result_age == 0))
    else $error("missing result carries data");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> in_stall)
    else $error("accepted word not held");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the day-keyed sorted sample store. A queue of words
// feeds a clocked driver with random gaps; a clocked monitor with random
// stalls checks each result against an in-bench model of the sorted table.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dkss_pkg::*;

  localparam logic signed [16:0] AGE_MIN = 17'sh10000;

  typedef struct {
    logic [1:0]         kind;
    logic [15:0]        today;
    logic [15:0]        sample;
    logic [15:0]        age_days;
    logic signed [16:0] age_from;
    logic signed [16:0] age_to;
  } word_t;

  typedef struct {
    logic [2:0]         status;
    logic [15:0]        value;
    logic signed [16:0] age;
  } result_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] kind = '0;
  logic [15:0] today = '0, sample = '0, age_days = '0;
  logic signed [16:0] age_from = '0, age_to = '0;
  logic [2:0] status;
  logic [15:0] result_value;
  logic signed [16:0] result_age;

  day_keyed_sorted_sample_store DUT (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  word_t pending[$];
  result_t expected_results[$];
  logic [15:0] tbl_day[TABLE_DEPTH];
  logic [15:0] tbl_val[TABLE_DEPTH];
  int tbl_cnt = 0;
  int errors = 0, words_in = 0, words_out = 0, idle_cycles = 0;
  bit hold_off = 0;
  int n_evict = 0, n_drop = 0, n_repl = 0;

  function automatic result_t predict_table(word_t w);
    result_t r;
    int i, j, cnt, ago;
    logic [15:0] want;
    logic [31:0] sum;
    r.status = ST_MISSING; r.value = '0; r.age = '0;
    case (w.kind)
      KIND_STORE: begin
        i = tbl_cnt;
        while (i > 0 && tbl_day[i-1] > w.today) i--;
        if (i > 0 && tbl_day[i-1] == w.today) begin
          tbl_val[i-1] = w.sample;
          r.status = ST_REPLACED;
        end else if (tbl_cnt >= TABLE_DEPTH && i == 0) begin
          r.status = ST_DROPPED;
        end else begin
          r.status = ST_INSERTED;
          if (tbl_cnt >= TABLE_DEPTH) begin
            for (j = 0; j < TABLE_DEPTH - 1; j++) begin
              tbl_day[j] = tbl_day[j+1]; tbl_val[j] = tbl_val[j+1];
            end
            tbl_cnt = TABLE_DEPTH - 1;
            i--;
            r.status = ST_EVICTED;
          end
          for (j = tbl_cnt; j > i; j--) begin
            tbl_day[j] = tbl_day[j-1]; tbl_val[j] = tbl_val[j-1];
          end
          tbl_day[i] = w.today; tbl_val[i] = w.sample;
          tbl_cnt++;
        end
      end
      KIND_GET: begin
        want = w.today - w.age_days;
        for (i = tbl_cnt - 1; i >= 0; i--) begin
          if (tbl_day[i] == want) begin
            r.status = ST_FOUND; r.value = tbl_val[i]; break;
          end
          if (tbl_day[i] < want) break;
        end
      end
      KIND_AVG: begin
        sum = 0; cnt = 0;
        for (i = 0; i < tbl_cnt; i++) begin
          ago = int'(w.today) - int'(tbl_day[i]);
          if (ago >= int'(w.age_from) && ago <= int'(w.age_to)) begin
            sum += tbl_val[i]; cnt++;
          end
        end
        if (cnt != 0) begin
          r.status = ST_FOUND; r.value = 16'(sum / cnt);
        end
      end
      default: begin
        if (tbl_cnt != 0) begin
          r.status = ST_FOUND;
          r.value = tbl_val[tbl_cnt-1];
          r.age = 17'(int'(w.today) - int'(tbl_day[tbl_cnt-1]));
        end
      end
    endcase
    return r;
  endfunction

  // acceptance seen at the rising edge
  bit in_taken = 0;
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (in_valid && !in_stall) words_in++;
  end

  // driver
  int gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // held word still pending
      end else if (gap > 0 || hold_off || pending.size() == 0) begin
        in_valid <= 0;
        if (gap > 0) gap <= gap - 1;
      end else begin
        word_t w;
        w = pending.pop_front();
        kind <= w.kind; today <= w.today; sample <= w.sample;
        age_days <= w.age_days; age_from <= w.age_from; age_to <= w.age_to;
        in_valid <= 1;
        expected_results.push_back(predict_table(w));
        gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end
    end
  end

  // monitor
  int stall_left = 0;
  bit out_taken = 0;
  always @(posedge clk) begin
    out_taken <= out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      result_t e;
      words_out++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%0d age=%0d",
                 $time, status, result_value, result_age);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status);
          errors++;
        end
        if (result_value !== e.value) begin
          $display("%0t: value exp %0d got %0d", $time, e.value, result_value);
          errors++;
        end
        if (result_age !== e.age) begin
          $display("%0t: age exp %0d got %0d", $time, e.age, result_age);
          errors++;
        end
        case (e.status)
          ST_EVICTED: n_evict++;
          ST_DROPPED: n_drop++;
          ST_REPLACED: n_repl++;
          default: ;
        endcase
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result stall: a fresh wait drawn after each taken word
  always @(negedge clk) begin
    int s;
    s = stall_left;
    if (out_taken) s = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 12);
    else if (out_valid && s > 0) s = s - 1;
    stall_left <= s;
    out_stall <= (s > 0);
  end

  function automatic word_t mk(logic [1:0] k, logic [15:0] d, logic [15:0] v,
                               logic [15:0] a, logic signed [16:0] f,
                               logic signed [16:0] t);
    word_t w;
    w.kind = k; w.today = d; w.sample = v; w.age_days = a;
    w.age_from = f; w.age_to = t;
    return w;
  endfunction

  function automatic word_t rand_word(int base, bit wide);
    word_t w;
    int r;
    r = $urandom_range(0, 9);
    w = mk(KIND_STORE, 16'($urandom), 16'($urandom), 16'($urandom),
           17'($urandom), 17'($urandom));
    if (!wide) begin
      w.today = 16'(base + $urandom_range(0, 60));
      w.age_days = 16'($urandom_range(0, 70));
      w.age_from = 17'(int'($urandom_range(0, 80)) - 20);
      w.age_to = 17'(int'(w.age_from) + int'($urandom_range(0, 50)) - 5);
    end
    w.kind = r < 5 ? KIND_STORE : r < 7 ? KIND_GET : r < 9 ? KIND_AVG : KIND_LAST;
    return w;
  endfunction

  initial begin
    int base;
    repeat (12) @(posedge clk);
    rst <= 0;
    // empty table, then extremes
    pending.push_back(mk(KIND_GET, 16'd5, 0, 0, 0, 0));
    pending.push_back(mk(KIND_AVG, 16'd5, 0, 0, AGE_MIN, 17'sd65535));
    pending.push_back(mk(KIND_LAST, 16'hFFFF, 0, 0, 0, 0));
    pending.push_back(mk(KIND_STORE, 16'hFFFF, 16'hFFFF, 0, 0, 0));
    pending.push_back(mk(KIND_STORE, 16'h0000, 16'h0000, 0, 0, 0));
    pending.push_back(mk(KIND_STORE, 16'hFFFF, 16'h1234, 0, 0, 0));
    pending.push_back(mk(KIND_LAST, 16'h0000, 0, 0, 0, 0));
    pending.push_back(mk(KIND_GET, 16'h0000, 0, 16'h0001, 0, 0));
    pending.push_back(mk(KIND_GET, 16'h0000, 0, 16'hFFFF, 0, 0));
    pending.push_back(mk(KIND_AVG, 16'hFFFF, 0, 0, AGE_MIN, 17'sd65535));
    pending.push_back(mk(KIND_AVG, 16'h0000, 0, 0, -17'sd65535, -17'sd65535));
    pending.push_back(mk(KIND_AVG, 16'h0000, 0, 0, 17'sd10, -17'sd10));
    for (int i = 0; i < 36; i++)
      pending.push_back(mk(KIND_STORE, 16'(100 + 2 * i), 16'($urandom), 0, 0, 0));
    pending.push_back(mk(KIND_STORE, 16'd1, 16'd7, 0, 0, 0));
    pending.push_back(mk(KIND_AVG, 16'd200, 0, 0, AGE_MIN, 17'sd65535));
    pending.push_back(mk(KIND_LAST, 16'd10, 0, 0, 0, 0));
    // let everything drain before random traffic
    wait (pending.size() == 0);
    hold_off = 1;
    wait (expected_results.size() == 0);
    hold_off = 0;
    base = 1000;
    for (int n = 0; n < 1350; n++) begin
      if (n % 150 == 0) base = $urandom_range(0, 65535 - 70);
      pending.push_back(rand_word(base, $urandom_range(0, 9) == 0));
    end
    wait (pending.size() == 0 && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d words in, %0d results; evictions %0d, drops %0d, replaces %0d",
             words_in, words_out, n_evict, n_drop, n_repl);
    if (errors == 0 && expected_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
